FILE: hdl/anagram_group_classifier_assert.svh
// ----------------------------------------------------------------------------
// Anagram group classifier assertion macros
// Shared concurrent assertion forms, sampled on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef ANAGRAM_GROUP_CLASSIFIER_ASSERT_SVH
`define ANAGRAM_GROUP_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define AGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Assertion failed.");

`endif

FILE: hdl/agc_pkg.sv
// ----------------------------------------------------------------------------
// Anagram group classifier package
// Shared types, constants and the letter decode function.
// ----------------------------------------------------------------------------
package agc_pkg;

  localparam int unsigned NumBins = 26;
  localparam int unsigned BinW    = 5;
  localparam logic [BinW-1:0] BinMax = 5'd31;
  localparam logic [7:0] UpperA   = 8'h41;
  localparam logic [7:0] LowerA   = 8'h61;

  typedef logic [BinW-1:0] bin_t;
  typedef bin_t [NumBins-1:0] hist_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       word_end;
    logic       clear_set;
  } req_t;

  typedef struct packed {
    logic [5:0] group_id;
    logic       new_group;
    logic [4:0] word_number;
    logic       table_full;
  } result_t;

  typedef struct packed {
    hist_t hist;
    logic  clr;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } letter_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackSearch,
    BackFinish
  } back_state_e;

  function automatic letter_t letter_bin(logic [7:0] c);
    letter_t    res;
    logic [7:0] du;
    logic [7:0] dl;
    du = c - UpperA;
    dl = c - LowerA;
    res.hit = 1'b0;
    res.idx = '0;
    if (c >= UpperA && du < 8'(NumBins)) begin
      res.hit = 1'b1;
      res.idx = du[4:0];
    end else if (c >= LowerA && dl < 8'(NumBins)) begin
      res.hit = 1'b1;
      res.idx = dl[4:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/agc_front.sv
// ----------------------------------------------------------------------------
// Anagram group classifier front end
// Accepts characters, builds the letter histogram and hands finished words on.
// ----------------------------------------------------------------------------
`include "anagram_group_classifier_assert.svh"

module agc_front import agc_pkg::*; #(
  parameter int unsigned MaxWordLen = 31
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  logic  push,
  output logic  full,
  input  logic  job_full_i,
  output logic  job_push_o,
  output job_t  job_o
);

  localparam int unsigned CntW = $clog2(MaxWordLen + 1);

  hist_t           hist_q, hist_d, hist_upd;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            clr_q, clr_d;
  logic            accept;
  letter_t         lb;

  assign full   = job_full_i;
  assign accept = push && !job_full_i;
  assign lb     = letter_bin(req_i.char_code);

  always_comb begin
    hist_upd = hist_q;
    if (cnt_q < CntW'(MaxWordLen)) begin
      for (int i = 0; i < NumBins; i++) begin
        if (lb.hit && lb.idx == 5'(i) && hist_q[i] != BinMax) begin
          hist_upd[i] = hist_q[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    hist_d     = hist_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    job_push_o = 1'b0;
    job_o.hist = hist_upd;
    job_o.clr  = clr_q || req_i.clear_set;
    if (accept) begin
      if (req_i.word_end) begin
        job_push_o = 1'b1;
        hist_d     = '0;
        cnt_d      = '0;
        clr_d      = 1'b0;
      end else begin
        hist_d = hist_upd;
        clr_d  = clr_q || req_i.clear_set;
        if (cnt_q < CntW'(MaxWordLen)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      cnt_q  <= '0;
      clr_q  <= 1'b0;
    end else begin
      hist_q <= hist_d;
      cnt_q  <= cnt_d;
      clr_q  <= clr_d;
    end
  end

  `AGC_ASSERT_NEXT(a_word_restarts, accept && req_i.word_end, hist_q == '0 && cnt_q == '0 && !clr_q)
  `AGC_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CntW'(MaxWordLen))

endmodule

FILE: hdl/agc_job_fifo.sv
// ----------------------------------------------------------------------------
// Anagram group classifier word queue
// Two-entry queue of finished word histograms between front and back end.
// ----------------------------------------------------------------------------
module agc_job_fifo import agc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output job_t rdata_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/agc_back.sv
// ----------------------------------------------------------------------------
// Anagram group classifier back end
// Searches the stored histograms, issues group numbers and stores each word while the table has room.
// ----------------------------------------------------------------------------
`include "anagram_group_classifier_assert.svh"

module agc_back import agc_pkg::*; #(
  parameter int unsigned MaxWords = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    job_i,
  input  logic    job_empty_i,
  output logic    job_pop_o,
  output result_t result_o,
  output logic    empty,
  input  logic    pop
);

  localparam int unsigned IdxW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned CntW = $clog2(MaxWords + 1);

  typedef struct packed {
    logic [CntW-1:0] grp;
    hist_t           hist;
  } row_t;

  row_t            mem_q [MaxWords];
  row_t            rdata_q, wr_row;
  back_state_e     state_q, state_d;
  hist_t           hist_q, hist_d;
  logic [CntW-1:0] words_q, words_d, groups_q, groups_d, rd_k_q, rd_k_d;
  logic [CntW-1:0] gid_q, gid_d;
  logic            found_q, found_d, cmp_vld_q;
  logic            rd_en, mem_we, match, search_done, finish_fire, tbl_full;
  result_t         out_q, out_d;
  logic            out_vld_q, out_vld_d;

  assign match       = cmp_vld_q && rdata_q.hist == hist_q;
  assign search_done = match || rd_k_q >= words_q;
  assign tbl_full    = words_q >= CntW'(MaxWords);
  assign finish_fire = state_q == BackFinish && (!out_vld_q || pop);
  assign rd_en       = state_q == BackSearch && !match && rd_k_q < words_q;
  assign job_pop_o   = state_q == BackIdle && !job_empty_i;
  assign empty       = !out_vld_q;
  assign result_o    = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: begin
        if (!job_empty_i) begin
          state_d = BackSearch;
        end
      end
      BackSearch: begin
        if (search_done) begin
          state_d = BackFinish;
        end
      end
      BackFinish: begin
        if (!out_vld_q || pop) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_comb begin
    hist_d    = hist_q;
    words_d   = words_q;
    groups_d  = groups_q;
    rd_k_d    = rd_k_q;
    gid_d     = gid_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    wr_row    = '{grp: gid_q, hist: hist_q};
    out_d     = out_q;
    out_vld_d = out_vld_q && !pop;
    if (job_pop_o) begin
      hist_d = job_i.hist;
      rd_k_d = '0;
      if (job_i.clr) begin
        words_d  = '0;
        groups_d = '0;
      end
    end
    if (rd_en) begin
      rd_k_d = rd_k_q + 1'b1;
    end
    if (state_q == BackSearch && search_done) begin
      found_d = match;
      gid_d   = rdata_q.grp;
    end
    if (finish_fire) begin
      out_vld_d       = 1'b1;
      out_d.new_group = 1'b0;
      out_d.table_full = tbl_full;
      out_d.word_number = '0;
      out_d.group_id  = found_q ? 6'(gid_q) : '0;
      if (!tbl_full) begin
        if (!found_q) begin
          groups_d        = groups_q + 1'b1;
          wr_row.grp      = groups_q + 1'b1;
          out_d.group_id  = 6'(groups_q + 1'b1);
          out_d.new_group = 1'b1;
        end
        out_d.word_number = 5'(words_q);
        mem_we            = 1'b1;
        words_d           = words_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[words_q[IdxW-1:0]] <= wr_row;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_k_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
    gid_q  <= gid_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BackIdle;
      words_q   <= '0;
      groups_q  <= '0;
      rd_k_q    <= '0;
      found_q   <= 1'b0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      words_q   <= words_d;
      groups_q  <= groups_d;
      rd_k_q    <= rd_k_d;
      found_q   <= found_d;
      cmp_vld_q <= rd_en;
      out_vld_q <= out_vld_d;
    end
  end

  `AGC_ASSERT_NOW(a_words_bound, 1'b1, words_q <= CntW'(MaxWords) && groups_q <= words_q)
  `AGC_ASSERT_NOW(a_new_not_full, out_vld_q && out_q.new_group, !out_q.table_full)
  `AGC_ASSERT_NOW(a_compare_in_search, cmp_vld_q, state_q == BackSearch)
  `AGC_ASSERT_NEXT(a_store_advances, finish_fire && !tbl_full, words_q == CntW'($past(words_q) + 1'b1))

endmodule

FILE: hdl/anagram_group_classifier.sv
// ----------------------------------------------------------------------------
// Anagram group classifier
// Groups words by letter histogram and reports one result per word.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while full is low and case-folded into a
// 26-bin saturating histogram. A word end queues the histogram for the back end,
// which reads one stored word per cycle from a single-port table until it finds
// a match or runs out of stored words. A two-word queue lets characters keep
// flowing meanwhile; full rises only when that queue is full. Results wait in
// one output register and are taken with pop.
module anagram_group_classifier import agc_pkg::*; #(
  parameter int unsigned MAX_WORDS    = 32,
  parameter int unsigned MAX_WORD_LEN = 31
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  logic    push,
  output logic    full,
  output result_t result_o,
  output logic    empty,
  input  logic    pop
);

  job_t front_job, back_job;
  logic job_push, job_full, job_pop, job_empty;

  agc_front #(
    .MaxWordLen(MAX_WORD_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .push       (push),
    .full       (full),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (front_job)
  );

  agc_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (front_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (back_job),
    .empty_o (job_empty)
  );

  agc_back #(
    .MaxWords(MAX_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .result_o    (result_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

FILE: test/anagram_group_classifier_test.sv
// ----------------------------------------------------------------------------
// Anagram group classifier testbench
// Drives words one character per request, covering letter and non-letter
// bytes, clears, long and saturating words, and full tables. A tracker class
// keeps its own copy of the histograms and groups, works out the group result
// of each word end, and compares every popped result field by field. Sender
// gaps and receiver stalls vary by phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module anagram_group_classifier_test import agc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxWords      = 32;
  localparam int MaxWordLen    = 31;
  localparam int WatchLimit    = 2000;
  localparam int ItemsPerPhase = 175;
  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 60;

  class group_tracker;
    hist_t           word_hist;
    hist_t           saved_hist [MaxWords];
    logic [5:0]      saved_group[MaxWords];
    int unsigned     saved_count;
    int unsigned     group_count;
    int unsigned     char_count;
    result_t         due_results[$];
    int              errors;

    function new();
      word_hist   = '0;
      saved_count = 0;
      group_count = 0;
      char_count  = 0;
      errors      = 0;
    endfunction

    function void take_char(req_t r);
      int      bin;
      int      hit_slot;
      result_t res;
      bin      = -1;
      hit_slot = -1;
      res      = '0;
      if (r.clear_set) begin
        saved_count = 0;
        group_count = 0;
      end
      if (char_count < MaxWordLen) begin
        char_count++;
        if (r.char_code >= UpperA && r.char_code <= UpperA + 8'd25) begin
          bin = int'(r.char_code) - int'(UpperA);
        end else if (r.char_code >= LowerA && r.char_code <= LowerA + 8'd25) begin
          bin = int'(r.char_code) - int'(LowerA);
        end
        if (bin >= 0 && word_hist[bin] != BinMax) begin
          word_hist[bin] = word_hist[bin] + 1'b1;
        end
      end
      if (!r.word_end) return;
      for (int k = 0; k < int'(saved_count); k++) begin
        if (hit_slot < 0 && saved_hist[k] == word_hist) hit_slot = k;
      end
      if (saved_count >= MaxWords) begin
        res.table_full = 1'b1;
        if (hit_slot >= 0) res.group_id = saved_group[hit_slot];
      end else begin
        if (hit_slot >= 0) begin
          res.group_id = saved_group[hit_slot];
        end else begin
          group_count++;
          res.group_id  = 6'(group_count);
          res.new_group = 1'b1;
        end
        res.word_number          = 5'(saved_count);
        saved_hist[saved_count]  = word_hist;
        saved_group[saved_count] = res.group_id;
        saved_count++;
      end
      word_hist  = '0;
      char_count = 0;
      due_results.push_back(res);
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with no word end pending: %h", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.group_id !== want.group_id) begin
        $error("group_id: expected %0d, actual %0d", want.group_id, got.group_id);
        errors++;
      end
      if (got.new_group !== want.new_group) begin
        $error("new_group: expected %0d, actual %0d", want.new_group, got.new_group);
        errors++;
      end
      if (got.word_number !== want.word_number) begin
        $error("word_number: expected %0d, actual %0d", want.word_number,
               got.word_number);
        errors++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0d, actual %0d", want.table_full, got.table_full);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  req_t    req_i  = '0;
  logic    push   = 1'b0;
  logic    full;
  result_t result_o;
  logic    empty;
  logic    pop    = 1'b0;

  group_tracker tracker = new();

  int phase_sel = 0;
  int sent      = 0;
  int sender_idle[4]    = '{0, 72, 0, 9};
  int receiver_stall[4] = '{0, 0, 72, 9};

  logic [7:0] family[4][8];
  int         family_len[4];
  logic [7:0] word_buf[$];
  int         words_left = 0;

  anagram_group_classifier dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .push     (push),
    .full     (full),
    .result_o (result_o),
    .empty    (empty),
    .pop      (pop)
  );

  always #5 clk_i = ~clk_i;

  task automatic offer(input req_t r);
    req_i <= r;
    push  <= 1'b1;
    do @(posedge clk_i); while (full);
    tracker.take_char(r);
    sent++;
  endtask

  task automatic pace();
    while ($urandom_range(0, 99) < sender_idle[phase_sel]) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_raw(input logic [7:0] c, input logic e, input logic clr);
    req_t r;
    r.char_code = c;
    r.word_end  = e;
    r.clear_set = clr;
    pace();
    offer(r);
  endtask

  task automatic send_next_word();
    req_t       r;
    int         clr_at;
    int         kind;
    int         f;
    int         n;
    int         j;
    logic [7:0] tmp;
    logic [7:0] letter;
    bit         fresh;
    fresh = (words_left == 0);
    if (fresh) begin
      for (int a = 0; a < 4; a++) begin
        family_len[a] = $urandom_range(1, 6);
        for (int i = 0; i < 8; i++) family[a][i] = UpperA + 8'($urandom_range(0, 5));
      end
      words_left = ($urandom_range(0, 99) < 40) ? $urandom_range(33, 40)
                                                : $urandom_range(1, 12);
    end
    word_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      f = $urandom_range(0, 3);
      for (int i = 0; i < family_len[f]; i++) begin
        word_buf.push_back(family[f][i] | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      end
      for (int i = word_buf.size() - 1; i > 0; i--) begin
        j           = $urandom_range(0, i);
        tmp         = word_buf[i];
        word_buf[i] = word_buf[j];
        word_buf[j] = tmp;
      end
      if ($urandom_range(0, 4) == 0) begin
        word_buf.insert($urandom_range(0, word_buf.size()), 8'($urandom_range(0, 64)));
      end
    end else if (kind < 70) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        word_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 64))
                                                : 8'($urandom_range(123, 255)));
      end
    end else if (kind < 88) begin
      n = $urandom_range(1, 8);
      repeat (n) word_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      letter = UpperA + 8'($urandom_range(0, 25));
      n      = $urandom_range(32, 40);
      repeat (n) word_buf.push_back(letter | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    end else begin
      n = $urandom_range(28, 40);
      repeat (n) word_buf.push_back(8'($urandom_range(0, 255)));
    end
    clr_at = fresh ? $urandom_range(0, word_buf.size() - 1) : -1;
    for (int i = 0; i < word_buf.size(); i++) begin
      r.char_code = word_buf[i];
      r.word_end  = (i == word_buf.size() - 1);
      r.clear_set = (i == clr_at) || ($urandom_range(0, 199) == 0);
      pace();
      offer(r);
    end
    words_left--;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : receiver
    int hold_left = 0;
    bit hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) tracker.compare_result(result_o);
      if (!hold_done && phase_sel == 0 && sent >= 40) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= receiver_stall[phase_sel]);
      end
    end
  end

  initial begin : watchdog
    int quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("anagram_group_classifier_test: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_raw(8'h00,         1'b0, 1'b1);
    send_raw(UpperA,        1'b0, 1'b0);
    send_raw(LowerA + 8'd25, 1'b1, 1'b0);
    send_raw(UpperA + 8'd25, 1'b0, 1'b0);
    send_raw(LowerA,        1'b1, 1'b0);
    send_raw(8'hFF,         1'b1, 1'b0);
    send_raw(UpperA - 8'd1,  1'b0, 1'b0);
    send_raw(UpperA + 8'd26, 1'b0, 1'b0);
    send_raw(LowerA - 8'd1,  1'b0, 1'b0);
    send_raw(LowerA + 8'd26, 1'b1, 1'b0);
    send_raw(LowerA,        1'b0, 1'b0);
    send_raw(8'h80,         1'b0, 1'b1);
    send_raw(UpperA + 8'd1,  1'b1, 1'b0);
    send_raw(LowerA + 8'd1,  1'b0, 1'b0);
    send_raw(UpperA,        1'b1, 1'b0);
    send_raw(8'h7F,         1'b0, 1'b0);
    send_raw(UpperA,        1'b1, 1'b1);
    send_raw(LowerA + 8'd25, 1'b1, 1'b0);
    send_raw(8'h55,         1'b0, 1'b0);
    send_raw(8'hAA,         1'b1, 1'b0);
    push <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      phase_sel <= p;
      @(posedge clk_i);
      while (sent < (p + 1) * ItemsPerPhase) send_next_word();
      settle();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("anagram_group_classifier_test: clean");
    end else begin
      $display("anagram_group_classifier_test: errors");
    end
    $finish;
  end

endmodule
